FILE: rtl/core/tc8_pkg.sv
`timescale 1ns / 1ps

package tc8_pkg;

	localparam logic [7:0] ADR_TIFR  = 8'h15;
	localparam logic [7:0] ADR_GTCCR = 8'h23;
	localparam logic [7:0] ADR_TCCRA = 8'h24;
	localparam logic [7:0] ADR_TCCRB = 8'h25;
	localparam logic [7:0] ADR_TCNT  = 8'h26;
	localparam logic [7:0] ADR_OCRA  = 8'h27;
	localparam logic [7:0] ADR_OCRB  = 8'h28;
	localparam logic [7:0] ADR_TIMSK = 8'h4E;

	localparam logic [9:0] PRE_MASK_8    = 10'h007;
	localparam logic [9:0] PRE_MASK_64   = 10'h03F;
	localparam logic [9:0] PRE_MASK_256  = 10'h0FF;
	localparam logic [9:0] PRE_MASK_1024 = 10'h3FF;

	localparam logic [2:0] CS_STOP     = 3'd0;
	localparam logic [2:0] CS_DIV1     = 3'd1;
	localparam logic [2:0] CS_DIV8     = 3'd2;
	localparam logic [2:0] CS_DIV64    = 3'd3;
	localparam logic [2:0] CS_DIV256   = 3'd4;
	localparam logic [2:0] CS_DIV1024  = 3'd5;
	localparam logic [2:0] CS_EXT_FALL = 3'd6;
	localparam logic [2:0] CS_EXT_RISE = 3'd7;

	localparam logic [2:0] WGM_PHASE_FF  = 3'd1;
	localparam logic [2:0] WGM_CTC       = 3'd2;
	localparam logic [2:0] WGM_FAST_FF   = 3'd3;
	localparam logic [2:0] WGM_PHASE_OCA = 3'd5;
	localparam logic [2:0] WGM_FAST_OCA  = 3'd7;

	localparam logic [1:0] COM_OFF    = 2'd0;
	localparam logic [1:0] COM_TOGGLE = 2'd1;
	localparam logic [1:0] COM_CLEAR  = 2'd2;
	localparam logic [1:0] COM_SET    = 2'd3;

	localparam logic [1:0] EXT_FALL_SEEN = 2'b10;
	localparam logic [1:0] EXT_RISE_SEEN = 2'b01;

	typedef struct packed {
		logic       req_type;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       ext_clock_pin;
		logic       ack_overflow;
		logic       ack_compare_a;
		logic       ack_compare_b;
		logic [7:0] read_addr;
	} tc8_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] count_value;
		logic [9:0] prescaler_count;
		logic       pin_a;
		logic       pin_a_enable;
		logic       pin_b;
		logic       pin_b_enable;
		logic       irq_overflow;
		logic       irq_compare_a;
		logic       irq_compare_b;
	} tc8_result_t;

	function automatic logic com_nonpwm(input logic [1:0] com, input logic lvl);
		logic r;
		unique case (com)
			COM_TOGGLE: r = ~lvl;
			COM_CLEAR:  r = 1'b0;
			COM_SET:    r = 1'b1;
			default:    r = lvl;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/tc8_core.sv
`timescale 1ns / 1ps

module tc8_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  tc8_pkg::tc8_item_t   item,
	output tc8_pkg::tc8_result_t res
);

	logic [9:0] pre_q;
	logic       tsm_q, psr_async_q, psr_sync_q;
	logic [3:0] com_q;
	logic [2:0] wgm_q, cs_q;
	logic [7:0] cnt_q, ocra_act_q, ocra_buf_q, ocrb_act_q, ocrb_buf_q;
	logic [2:0] mask_q, flags_q;
	logic       down_q, blocked_q, pina_q, pinb_q;
	logic [2:0] ext_q;

	logic [9:0] pre_d;
	logic       tsm_d, psr_async_d, psr_sync_d;
	logic [3:0] com_d;
	logic [2:0] wgm_d, cs_d;
	logic [7:0] cnt_d, ocra_act_d, ocra_buf_d, ocrb_act_d, ocrb_buf_d;
	logic [2:0] mask_d, flags_d;
	logic       down_d, blocked_d, pina_d, pinb_d;
	logic [2:0] ext_d;

	logic       we, psr_now, tap, phase, fast, pwm, at_top, at_max, at_bot;
	logic       ev_ovf, ev_a, ev_b, ev_upd, foc_a, foc_b, wr_tifr;
	logic [7:0] top;
	logic [1:0] ca, cb, ca_n, cb_n;
	logic       phase_n, pwm_n;
	logic [7:0] rd;

	always_comb begin
		we = item.req_type;
		psr_now = (we && item.reg_addr == tc8_pkg::ADR_GTCCR) ? item.write_data[0] : psr_sync_q;
		unique case (cs_q)
			tc8_pkg::CS_DIV1:     tap = 1'b1;
			tc8_pkg::CS_DIV8:     tap = ((pre_q & tc8_pkg::PRE_MASK_8) == tc8_pkg::PRE_MASK_8)
				&& !psr_now;
			tc8_pkg::CS_DIV64:    tap = ((pre_q & tc8_pkg::PRE_MASK_64) == tc8_pkg::PRE_MASK_64)
				&& !psr_now;
			tc8_pkg::CS_DIV256:   tap = ((pre_q & tc8_pkg::PRE_MASK_256) == tc8_pkg::PRE_MASK_256)
				&& !psr_now;
			tc8_pkg::CS_DIV1024:  tap = (pre_q == tc8_pkg::PRE_MASK_1024) && !psr_now;
			tc8_pkg::CS_EXT_FALL: tap = (ext_q[2:1] == tc8_pkg::EXT_FALL_SEEN);
			tc8_pkg::CS_EXT_RISE: tap = (ext_q[2:1] == tc8_pkg::EXT_RISE_SEEN);
			default:              tap = 1'b0;
		endcase

		phase = (wgm_q == tc8_pkg::WGM_PHASE_FF) || (wgm_q == tc8_pkg::WGM_PHASE_OCA);
		fast  = (wgm_q == tc8_pkg::WGM_FAST_FF) || (wgm_q == tc8_pkg::WGM_FAST_OCA);
		pwm   = phase || fast;
		top   = (wgm_q == tc8_pkg::WGM_CTC || wgm_q == tc8_pkg::WGM_PHASE_OCA
			|| wgm_q == tc8_pkg::WGM_FAST_OCA) ? ocra_act_q : 8'hFF;
		at_top = (cnt_q == top);
		at_max = (cnt_q == 8'hFF);
		at_bot = (cnt_q == 8'h00);
		ev_ovf = tap && (phase ? (down_q && at_bot) : (fast ? at_top : at_max));
		ev_a   = tap && !blocked_q && (cnt_q == ocra_act_q);
		ev_b   = tap && !blocked_q && (cnt_q == ocrb_act_q);
		ev_upd = tap && pwm && at_top;
		ca = com_q[3:2];
		cb = com_q[1:0];

		cnt_d = cnt_q;
		down_d = down_q;
		blocked_d = blocked_q;
		if (tap) begin
			if (phase) begin
				if (down_q) begin
					if (at_bot) begin
						down_d = 1'b0;
						cnt_d = (top == 8'h00) ? 8'h00 : 8'h01;
					end else begin
						cnt_d = cnt_q - 8'd1;
					end
				end else begin
					if (at_top) begin
						down_d = 1'b1;
						cnt_d = (top == 8'h00) ? 8'h00 : cnt_q - 8'd1;
					end else begin
						cnt_d = cnt_q + 8'd1;
					end
				end
			end else begin
				cnt_d = at_top ? 8'h00 : cnt_q + 8'd1;
			end
			blocked_d = 1'b0;
		end

		ocra_act_d = ev_upd ? ocra_buf_q : ocra_act_q;
		ocrb_act_d = ev_upd ? ocrb_buf_q : ocrb_act_q;

		foc_a = we && item.reg_addr == tc8_pkg::ADR_TCCRB && item.write_data[7] && !pwm;
		foc_b = we && item.reg_addr == tc8_pkg::ADR_TCCRB && item.write_data[6] && !pwm;
		pina_d = pina_q;
		pinb_d = pinb_q;
		if (!pwm) begin
			if (ev_a || foc_a) pina_d = tc8_pkg::com_nonpwm(ca, pina_q);
			if (ev_b || foc_b) pinb_d = tc8_pkg::com_nonpwm(cb, pinb_q);
		end else if (fast) begin
			if (tap && at_top) begin
				if (ca == tc8_pkg::COM_CLEAR) pina_d = 1'b1;
				else if (ca == tc8_pkg::COM_SET) pina_d = 1'b0;
				if (cb == tc8_pkg::COM_CLEAR) pinb_d = 1'b1;
				else if (cb == tc8_pkg::COM_SET) pinb_d = 1'b0;
			end else begin
				if (ev_a) pina_d = tc8_pkg::com_nonpwm(ca, pina_q);
				if (ev_b && cb[1]) pinb_d = tc8_pkg::com_nonpwm(cb, pinb_q);
			end
		end else begin
			if (ev_a) begin
				if (ca == tc8_pkg::COM_TOGGLE) pina_d = ~pina_q;
				else if (ca == tc8_pkg::COM_CLEAR) pina_d = down_q;
				else if (ca == tc8_pkg::COM_SET) pina_d = ~down_q;
			end
			if (ev_b) begin
				if (cb == tc8_pkg::COM_CLEAR) pinb_d = down_q;
				else if (cb == tc8_pkg::COM_SET) pinb_d = ~down_q;
			end
		end

		// hardware set wins over ack or write-one-to-clear
		wr_tifr = we && item.reg_addr == tc8_pkg::ADR_TIFR;
		flags_d = flags_q;
		if (ev_ovf) flags_d[0] = 1'b1;
		else if (item.ack_overflow || (wr_tifr && item.write_data[0])) flags_d[0] = 1'b0;
		if (ev_a) flags_d[1] = 1'b1;
		else if (item.ack_compare_a || (wr_tifr && item.write_data[1])) flags_d[1] = 1'b0;
		if (ev_b) flags_d[2] = 1'b1;
		else if (item.ack_compare_b || (wr_tifr && item.write_data[2])) flags_d[2] = 1'b0;

		com_d = com_q;
		wgm_d = wgm_q;
		cs_d = cs_q;
		ocra_buf_d = ocra_buf_q;
		ocrb_buf_d = ocrb_buf_q;
		mask_d = mask_q;
		if (we) begin
			unique case (item.reg_addr)
				tc8_pkg::ADR_TCCRA: begin
					com_d = item.write_data[7:4];
					wgm_d = {wgm_q[2], item.write_data[1:0]};
				end
				tc8_pkg::ADR_TCCRB: begin
					wgm_d = {item.write_data[3], wgm_q[1:0]};
					cs_d = item.write_data[2:0];
				end
				tc8_pkg::ADR_TCNT: begin
					cnt_d = item.write_data;
					blocked_d = 1'b1;
				end
				tc8_pkg::ADR_OCRA: begin
					ocra_buf_d = item.write_data;
					if (!pwm) ocra_act_d = item.write_data;
				end
				tc8_pkg::ADR_OCRB: begin
					ocrb_buf_d = item.write_data;
					if (!pwm) ocrb_act_d = item.write_data;
				end
				tc8_pkg::ADR_TIMSK: mask_d = item.write_data[2:0];
				default: ;
			endcase
		end

		tsm_d = tsm_q;
		psr_async_d = psr_async_q;
		psr_sync_d = psr_sync_q;
		if (we && item.reg_addr == tc8_pkg::ADR_GTCCR) begin
			tsm_d = item.write_data[7];
			psr_async_d = item.write_data[7] & item.write_data[1];
			psr_sync_d = item.write_data[7] & item.write_data[0];
		end else if (!tsm_q) begin
			psr_async_d = 1'b0;
			psr_sync_d = 1'b0;
		end
		pre_d = psr_now ? 10'd0 : pre_q + 10'd1;
		ext_d = {ext_q[1:0], item.ext_clock_pin};

		unique case (item.read_addr)
			tc8_pkg::ADR_TIFR:  rd = {5'd0, flags_d};
			tc8_pkg::ADR_GTCCR: rd = {tsm_d, 5'd0, psr_async_d, psr_sync_d};
			tc8_pkg::ADR_TCCRA: rd = {com_d, 2'd0, wgm_d[1:0]};
			tc8_pkg::ADR_TCCRB: rd = {4'd0, wgm_d[2], cs_d};
			tc8_pkg::ADR_TCNT:  rd = cnt_d;
			tc8_pkg::ADR_OCRA:  rd = ocra_buf_d;
			tc8_pkg::ADR_OCRB:  rd = ocrb_buf_d;
			tc8_pkg::ADR_TIMSK: rd = {5'd0, mask_d};
			default:            rd = 8'h00;
		endcase

		phase_n = (wgm_d == tc8_pkg::WGM_PHASE_FF) || (wgm_d == tc8_pkg::WGM_PHASE_OCA);
		pwm_n = phase_n || (wgm_d == tc8_pkg::WGM_FAST_FF) || (wgm_d == tc8_pkg::WGM_FAST_OCA);
		ca_n = com_d[3:2];
		cb_n = com_d[1:0];

		res.read_data       = rd;
		res.count_value     = cnt_d;
		res.prescaler_count = pre_d;
		res.pin_a           = pina_d;
		res.pin_a_enable    = (ca_n != tc8_pkg::COM_OFF)
			&& !(pwm_n && ca_n == tc8_pkg::COM_TOGGLE && !wgm_d[2]);
		res.pin_b           = pinb_d;
		res.pin_b_enable    = (cb_n != tc8_pkg::COM_OFF)
			&& !(pwm_n && cb_n == tc8_pkg::COM_TOGGLE);
		res.irq_overflow    = flags_d[0] & mask_d[0];
		res.irq_compare_a   = flags_d[1] & mask_d[1];
		res.irq_compare_b   = flags_d[2] & mask_d[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= '0;
			tsm_q <= 1'b0;
			psr_async_q <= 1'b0;
			psr_sync_q <= 1'b0;
			com_q <= '0;
			wgm_q <= '0;
			cs_q <= tc8_pkg::CS_STOP;
			cnt_q <= '0;
			ocra_act_q <= '0;
			ocra_buf_q <= '0;
			ocrb_act_q <= '0;
			ocrb_buf_q <= '0;
			mask_q <= '0;
			flags_q <= '0;
			down_q <= 1'b0;
			blocked_q <= 1'b0;
			pina_q <= 1'b0;
			pinb_q <= 1'b0;
			ext_q <= '0;
		end else if (en) begin
			pre_q <= pre_d;
			tsm_q <= tsm_d;
			psr_async_q <= psr_async_d;
			psr_sync_q <= psr_sync_d;
			com_q <= com_d;
			wgm_q <= wgm_d;
			cs_q <= cs_d;
			cnt_q <= cnt_d;
			ocra_act_q <= ocra_act_d;
			ocra_buf_q <= ocra_buf_d;
			ocrb_act_q <= ocrb_act_d;
			ocrb_buf_q <= ocrb_buf_d;
			mask_q <= mask_d;
			flags_q <= flags_d;
			down_q <= down_d;
			blocked_q <= blocked_d;
			pina_q <= pina_d;
			pinb_q <= pinb_d;
			ext_q <= ext_d;
		end
	end

	a_tcnt_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		en && we && item.reg_addr == tc8_pkg::ADR_TCNT |=> blocked_q)
		else $error("counter write did not block compare");

	a_pre_runs: assert property (@(posedge clk) disable iff (!arst_n)
		en && !psr_now |=> pre_q == 10'($past(pre_q) + 10'd1))
		else $error("prescaler did not advance");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cnt_q) && $stable(flags_q) && $stable(pre_q))
		else $error("state moved without a transfer");

	a_ovf_flag: assert property (@(posedge clk) disable iff (!arst_n)
		en && ev_ovf |=> flags_q[0])
		else $error("overflow flag lost");

endmodule

FILE: rtl/core/eight_bit_timer_counter_pwm_core.sv
`timescale 1ns / 1ps

// 8-bit timer/counter with two compare units (Timer0 register map). Each input transfer
// is one peripheral clock cycle: an optional register write, the T0 level and the three
// interrupt acknowledges. One result transfer follows each input transfer, via the input
// and result registers when the output is ready; a new input transfer is taken every cycle
// while results are accepted. All timer state is updated as an item moves from the input
// register into the result register. The result holds read_data for read_addr after the
// cycle, counter, prescaler, pin levels and enables, and masked interrupt requests.
// OCR0A/OCR0B read back the buffer value. Unmapped addresses read zero.
module eight_bit_timer_counter_pwm_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	input  logic       ext_clock_pin,
	input  logic       ack_overflow,
	input  logic       ack_compare_a,
	input  logic       ack_compare_b,
	input  logic [7:0] read_addr,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] count_value,
	output logic [9:0] prescaler_count,
	output logic       pin_a,
	output logic       pin_a_enable,
	output logic       pin_b,
	output logic       pin_b_enable,
	output logic       irq_overflow,
	output logic       irq_compare_a,
	output logic       irq_compare_b
);

	tc8_pkg::tc8_item_t   item_s1;
	logic                 valid_s1;
	tc8_pkg::tc8_result_t res_c;
	tc8_pkg::tc8_result_t res_s2;
	logic                 valid_s2;
	logic                 adv;
	logic                 in_xfer;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.req_type      <= req_type;
			item_s1.reg_addr      <= reg_addr;
			item_s1.write_data    <= write_data;
			item_s1.ext_clock_pin <= ext_clock_pin;
			item_s1.ack_overflow  <= ack_overflow;
			item_s1.ack_compare_a <= ack_compare_a;
			item_s1.ack_compare_b <= ack_compare_b;
			item_s1.read_addr     <= read_addr;
		end
		if (adv) res_s2 <= res_c;
	end

	tc8_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.res    (res_c)
	);

	assign out_valid       = valid_s2;
	assign read_data       = res_s2.read_data;
	assign count_value     = res_s2.count_value;
	assign prescaler_count = res_s2.prescaler_count;
	assign pin_a           = res_s2.pin_a;
	assign pin_a_enable    = res_s2.pin_a_enable;
	assign pin_b           = res_s2.pin_b;
	assign pin_b_enable    = res_s2.pin_b_enable;
	assign irq_overflow    = res_s2.irq_overflow;
	assign irq_compare_a   = res_s2.irq_compare_a;
	assign irq_compare_b   = res_s2.irq_compare_b;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2)
		else $error("pending result dropped");

	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result register not loaded");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost an item");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int HOLD_CYCLES = 200;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       req_type;
	logic [7:0] reg_addr;
	logic [7:0] write_data;
	logic       ext_clock_pin;
	logic       ack_overflow;
	logic       ack_compare_a;
	logic       ack_compare_b;
	logic [7:0] read_addr;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	logic [7:0] count_value;
	logic [9:0] prescaler_count;
	logic       pin_a;
	logic       pin_a_enable;
	logic       pin_b;
	logic       pin_b_enable;
	logic       irq_overflow;
	logic       irq_compare_a;
	logic       irq_compare_b;

	eight_bit_timer_counter_pwm_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.reg_addr(reg_addr),
		.write_data(write_data),
		.ext_clock_pin(ext_clock_pin),
		.ack_overflow(ack_overflow),
		.ack_compare_a(ack_compare_a),
		.ack_compare_b(ack_compare_b),
		.read_addr(read_addr),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.count_value(count_value),
		.prescaler_count(prescaler_count),
		.pin_a(pin_a),
		.pin_a_enable(pin_a_enable),
		.pin_b(pin_b),
		.pin_b_enable(pin_b_enable),
		.irq_overflow(irq_overflow),
		.irq_compare_a(irq_compare_a),
		.irq_compare_b(irq_compare_b)
	);

	// timer state as predicted
	logic [9:0] t_presc = '0;
	logic       t_tsm = 1'b0;
	logic       t_psr_async = 1'b0;
	logic       t_psr_sync = 1'b0;
	logic [3:0] t_com = '0;
	logic [2:0] t_wgm = '0;
	logic [2:0] t_cs = '0;
	logic [7:0] t_cnt = '0;
	logic [7:0] t_ocra = '0;
	logic [7:0] t_ocra_buf = '0;
	logic [7:0] t_ocrb = '0;
	logic [7:0] t_ocrb_buf = '0;
	logic [2:0] t_mask = '0;
	logic [2:0] t_flags = '0;
	logic       t_down = 1'b0;
	logic       t_blocked = 1'b0;
	logic       t_lvl_a = 1'b0;
	logic       t_lvl_b = 1'b0;
	logic [2:0] t_t0_sync = '0;

	tc8_pkg::tc8_result_t timer_views[$];
	tc8_pkg::tc8_result_t want;

	int mismatches = 0;
	int items_sent = 0;
	int views_checked = 0;
	int timer_ticks = 0;
	int overflow_events = 0;
	int match_events = 0;
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int hold_tag = 0;
	int hold_seen = 0;
	int hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic match_level(input logic [1:0] com, input logic lvl);
		case (com)
			tc8_pkg::COM_TOGGLE: return ~lvl;
			tc8_pkg::COM_CLEAR:  return 1'b0;
			tc8_pkg::COM_SET:    return 1'b1;
			default:             return lvl;
		endcase
	endfunction

	function automatic tc8_pkg::tc8_result_t step_timer(input tc8_pkg::tc8_item_t it);
		tc8_pkg::tc8_result_t r;
		logic wr, psr_now, tap, phase, fast, pwm, at_top, at_max, at_bot;
		logic ev_ovf, ev_a, ev_b, dir_in, foc_a, foc_b, wf, pwm_after;
		logic [7:0] top;
		logic [7:0] wd;
		logic [1:0] ca, cb;
		wr = it.req_type;
		wd = it.write_data;
		psr_now = (wr && it.reg_addr == tc8_pkg::ADR_GTCCR) ? wd[0] : t_psr_sync;
		case (t_cs)
			tc8_pkg::CS_DIV1:     tap = 1'b1;
			tc8_pkg::CS_DIV8:     tap = (t_presc & tc8_pkg::PRE_MASK_8) == tc8_pkg::PRE_MASK_8
				&& !psr_now;
			tc8_pkg::CS_DIV64:    tap = (t_presc & tc8_pkg::PRE_MASK_64) == tc8_pkg::PRE_MASK_64
				&& !psr_now;
			tc8_pkg::CS_DIV256:   tap = (t_presc & tc8_pkg::PRE_MASK_256)
				== tc8_pkg::PRE_MASK_256 && !psr_now;
			tc8_pkg::CS_DIV1024:  tap = (t_presc & tc8_pkg::PRE_MASK_1024)
				== tc8_pkg::PRE_MASK_1024 && !psr_now;
			tc8_pkg::CS_EXT_FALL: tap = t_t0_sync[2:1] == tc8_pkg::EXT_FALL_SEEN;
			tc8_pkg::CS_EXT_RISE: tap = t_t0_sync[2:1] == tc8_pkg::EXT_RISE_SEEN;
			default:              tap = 1'b0;
		endcase
		phase = t_wgm == tc8_pkg::WGM_PHASE_FF || t_wgm == tc8_pkg::WGM_PHASE_OCA;
		fast = t_wgm == tc8_pkg::WGM_FAST_FF || t_wgm == tc8_pkg::WGM_FAST_OCA;
		pwm = phase || fast;
		top = (t_wgm == tc8_pkg::WGM_CTC || t_wgm == tc8_pkg::WGM_PHASE_OCA
			|| t_wgm == tc8_pkg::WGM_FAST_OCA) ? t_ocra : 8'hFF;
		at_top = t_cnt == top;
		at_max = t_cnt == 8'hFF;
		at_bot = t_cnt == 8'h00;
		ev_ovf = tap && (phase ? (t_down && at_bot) : (fast ? at_top : at_max));
		ev_a = tap && !t_blocked && t_cnt == t_ocra;
		ev_b = tap && !t_blocked && t_cnt == t_ocrb;
		dir_in = t_down;
		ca = t_com[3:2];
		cb = t_com[1:0];
		overflow_events += int'(ev_ovf);
		match_events += int'(ev_a) + int'(ev_b);

		if (tap) begin
			if (phase) begin
				if (t_down && at_bot) begin
					t_down = 1'b0;
					t_cnt = (top == 8'h00) ? 8'h00 : 8'h01;
				end else if (t_down) begin
					t_cnt = t_cnt - 8'd1;
				end else if (at_top) begin
					t_down = 1'b1;
					t_cnt = (top == 8'h00) ? 8'h00 : t_cnt - 8'd1;
				end else begin
					t_cnt = t_cnt + 8'd1;
				end
			end else begin
				t_cnt = at_top ? 8'h00 : t_cnt + 8'd1;
			end
			t_blocked = 1'b0;
			timer_ticks++;
		end
		if (tap && pwm && at_top) begin
			t_ocra = t_ocra_buf;
			t_ocrb = t_ocrb_buf;
		end

		foc_a = wr && it.reg_addr == tc8_pkg::ADR_TCCRB && wd[7] && !pwm;
		foc_b = wr && it.reg_addr == tc8_pkg::ADR_TCCRB && wd[6] && !pwm;
		if (!pwm) begin
			if (ev_a || foc_a) t_lvl_a = match_level(ca, t_lvl_a);
			if (ev_b || foc_b) t_lvl_b = match_level(cb, t_lvl_b);
		end else if (fast) begin
			if (tap && at_top) begin
				if (ca == tc8_pkg::COM_CLEAR) t_lvl_a = 1'b1;
				else if (ca == tc8_pkg::COM_SET) t_lvl_a = 1'b0;
				if (cb == tc8_pkg::COM_CLEAR) t_lvl_b = 1'b1;
				else if (cb == tc8_pkg::COM_SET) t_lvl_b = 1'b0;
			end else begin
				if (ev_a) t_lvl_a = match_level(ca, t_lvl_a);
				if (ev_b && (cb == tc8_pkg::COM_CLEAR || cb == tc8_pkg::COM_SET))
					t_lvl_b = match_level(cb, t_lvl_b);
			end
		end else begin
			if (ev_a) begin
				case (ca)
					tc8_pkg::COM_TOGGLE: t_lvl_a = ~t_lvl_a;
					tc8_pkg::COM_CLEAR:  t_lvl_a = dir_in;
					tc8_pkg::COM_SET:    t_lvl_a = ~dir_in;
					default:             ;
				endcase
			end
			if (ev_b) begin
				case (cb)
					tc8_pkg::COM_CLEAR: t_lvl_b = dir_in;
					tc8_pkg::COM_SET:   t_lvl_b = ~dir_in;
					default:            ;
				endcase
			end
		end

		// hardware set wins over clear
		wf = wr && it.reg_addr == tc8_pkg::ADR_TIFR;
		if (ev_ovf) t_flags[0] = 1'b1;
		else if (it.ack_overflow || (wf && wd[0])) t_flags[0] = 1'b0;
		if (ev_a) t_flags[1] = 1'b1;
		else if (it.ack_compare_a || (wf && wd[1])) t_flags[1] = 1'b0;
		if (ev_b) t_flags[2] = 1'b1;
		else if (it.ack_compare_b || (wf && wd[2])) t_flags[2] = 1'b0;

		if (wr) begin
			case (it.reg_addr)
				tc8_pkg::ADR_TCCRA: begin
					t_com = wd[7:4];
					t_wgm[1:0] = wd[1:0];
				end
				tc8_pkg::ADR_TCCRB: begin
					t_wgm[2] = wd[3];
					t_cs = wd[2:0];
				end
				tc8_pkg::ADR_TCNT: begin
					t_cnt = wd;
					t_blocked = 1'b1;
				end
				tc8_pkg::ADR_OCRA: begin
					t_ocra_buf = wd;
					if (!pwm) t_ocra = wd;
				end
				tc8_pkg::ADR_OCRB: begin
					t_ocrb_buf = wd;
					if (!pwm) t_ocrb = wd;
				end
				tc8_pkg::ADR_TIMSK: t_mask = wd[2:0];
				default: ;
			endcase
		end

		if (wr && it.reg_addr == tc8_pkg::ADR_GTCCR) begin
			t_tsm = wd[7];
			t_psr_async = wd[7] & wd[1];
			t_psr_sync = wd[7] & wd[0];
		end else if (!t_tsm) begin
			t_psr_async = 1'b0;
			t_psr_sync = 1'b0;
		end
		t_presc = psr_now ? 10'd0 : t_presc + 10'd1;
		t_t0_sync = {t_t0_sync[1:0], it.ext_clock_pin};

		case (it.read_addr)
			tc8_pkg::ADR_TIFR:  r.read_data = {5'd0, t_flags};
			tc8_pkg::ADR_GTCCR: r.read_data = {t_tsm, 5'd0, t_psr_async, t_psr_sync};
			tc8_pkg::ADR_TCCRA: r.read_data = {t_com, 2'd0, t_wgm[1:0]};
			tc8_pkg::ADR_TCCRB: r.read_data = {4'd0, t_wgm[2], t_cs};
			tc8_pkg::ADR_TCNT:  r.read_data = t_cnt;
			tc8_pkg::ADR_OCRA:  r.read_data = t_ocra_buf;
			tc8_pkg::ADR_OCRB:  r.read_data = t_ocrb_buf;
			tc8_pkg::ADR_TIMSK: r.read_data = {5'd0, t_mask};
			default:            r.read_data = 8'h00;
		endcase
		pwm_after = t_wgm == tc8_pkg::WGM_PHASE_FF || t_wgm == tc8_pkg::WGM_PHASE_OCA ||
			t_wgm == tc8_pkg::WGM_FAST_FF || t_wgm == tc8_pkg::WGM_FAST_OCA;
		ca = t_com[3:2];
		cb = t_com[1:0];
		r.count_value = t_cnt;
		r.prescaler_count = t_presc;
		r.pin_a = t_lvl_a;
		r.pin_a_enable = ca != tc8_pkg::COM_OFF
			&& !(pwm_after && ca == tc8_pkg::COM_TOGGLE && !t_wgm[2]);
		r.pin_b = t_lvl_b;
		r.pin_b_enable = cb != tc8_pkg::COM_OFF && !(pwm_after && cb == tc8_pkg::COM_TOGGLE);
		r.irq_overflow = t_flags[0] & t_mask[0];
		r.irq_compare_a = t_flags[1] & t_mask[1];
		r.irq_compare_b = t_flags[2] & t_mask[2];
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (timer_views.size() == 0) begin
				$error("result transfer with nothing outstanding");
				mismatches++;
			end else begin
				want = timer_views.pop_front();
				views_checked++;
				check_field("read_data", 32'(want.read_data), 32'(read_data));
				check_field("count_value", 32'(want.count_value), 32'(count_value));
				check_field("prescaler_count", 32'(want.prescaler_count),
					32'(prescaler_count));
				check_field("pin_a", 32'(want.pin_a), 32'(pin_a));
				check_field("pin_a_enable", 32'(want.pin_a_enable), 32'(pin_a_enable));
				check_field("pin_b", 32'(want.pin_b), 32'(pin_b));
				check_field("pin_b_enable", 32'(want.pin_b_enable), 32'(pin_b_enable));
				check_field("irq_overflow", 32'(want.irq_overflow), 32'(irq_overflow));
				check_field("irq_compare_a", 32'(want.irq_compare_a), 32'(irq_compare_a));
				check_field("irq_compare_b", 32'(want.irq_compare_b), 32'(irq_compare_b));
			end
		end
	end

	// output side; a hold-off request is picked up through hold_tag
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_tag != hold_seen) begin
				hold_seen = hold_tag;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = $urandom_range(99) >= stall_pct;
			end
		end
	end

	function automatic tc8_pkg::tc8_item_t make_cycle(input logic we, input logic [7:0] addr,
			input logic [7:0] data, input logic t0, input logic [2:0] acks,
			input logic [7:0] raddr);
		tc8_pkg::tc8_item_t it;
		it.req_type = we;
		it.reg_addr = addr;
		it.write_data = data;
		it.ext_clock_pin = t0;
		it.ack_overflow = acks[2];
		it.ack_compare_a = acks[1];
		it.ack_compare_b = acks[0];
		it.read_addr = raddr;
		return it;
	endfunction

	task automatic send_cycle(input tc8_pkg::tc8_item_t it);
		in_valid = 1'b1;
		{req_type, reg_addr, write_data, ext_clock_pin, ack_overflow, ack_compare_a,
			ack_compare_b, read_addr} = it;
		do @(posedge clk); while (!in_ready);
		timer_views.push_back(step_timer(it));
		items_sent++;
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic drain;
		in_valid = 1'b0;
		while (timer_views.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_reg;
		case ($urandom_range(7))
			0: return tc8_pkg::ADR_TIFR;
			1: return tc8_pkg::ADR_GTCCR;
			2: return tc8_pkg::ADR_TCCRA;
			3: return tc8_pkg::ADR_TCCRB;
			4: return tc8_pkg::ADR_TCNT;
			5: return tc8_pkg::ADR_OCRA;
			6: return tc8_pkg::ADR_OCRB;
			default: return tc8_pkg::ADR_TIMSK;
		endcase
	endfunction

	function automatic tc8_pkg::tc8_item_t free_cycle;
		logic [7:0] addr, data, raddr;
		logic [2:0] acks;
		logic we;
		we = $urandom_range(99) < 6;
		addr = ($urandom_range(9) < 7) ? pick_reg() : 8'($urandom_range(255));
		data = 8'($urandom_range(255));
		// keep the prescaler from being frozen by hold plus sync reset
		if (addr == tc8_pkg::ADR_GTCCR && $urandom_range(3) != 0) data[7] = 1'b0;
		acks[2] = $urandom_range(9) == 0;
		acks[1] = $urandom_range(9) == 0;
		acks[0] = $urandom_range(9) == 0;
		raddr = ($urandom_range(9) < 8) ? pick_reg() : 8'($urandom_range(255));
		return make_cycle(we, addr, data, 1'($urandom_range(1)), acks, raddr);
	endfunction

	task automatic configure_timer;
		logic [7:0] d;
		if ($urandom_range(4) == 0)
			send_cycle(make_cycle(1'b1, tc8_pkg::ADR_GTCCR, 8'h00, 1'($urandom_range(1)),
				3'b000, pick_reg()));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRA, 8'($urandom_range(255)),
			1'($urandom_range(1)), 3'b000, pick_reg()));
		d = 8'($urandom_range(255));
		if ($urandom_range(9) < 3) d = 8'($urandom_range(7));
		else if ($urandom_range(9) == 0) d = 8'hFF;
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_OCRA, d, 1'($urandom_range(1)), 3'b000,
			pick_reg()));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_OCRB, 8'($urandom_range(255)),
			1'($urandom_range(1)), 3'b000, pick_reg()));
		d = 8'($urandom_range(255));
		if ($urandom_range(1) == 1) d[7:5] = 3'b111;
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCNT, d, 1'($urandom_range(1)), 3'b000,
			pick_reg()));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TIMSK, 8'($urandom_range(255)),
			1'($urandom_range(1)), 3'b000, pick_reg()));
		d = 8'($urandom_range(255));
		if ($urandom_range(9) < 4) d[2:0] = tc8_pkg::CS_DIV1;
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRB, d, 1'($urandom_range(1)), 3'b000,
			pick_reg()));
	endtask

	task automatic run_random(input int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(9) < 8) configure_timer();
			repeat ($urandom_range(20, 120))
				if (items_sent < target) send_cycle(free_cycle());
		end
	endtask

	task automatic test_register_map_and_modes;
		sender_idle_pct = 0;
		stall_pct = 0;
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TIMSK, 8'hFF, 1'b0, 3'b000,
			tc8_pkg::ADR_TIMSK));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_OCRA, 8'h02, 1'b0, 3'b000,
			tc8_pkg::ADR_OCRA));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_OCRB, 8'h01, 1'b0, 3'b000,
			tc8_pkg::ADR_OCRB));
		// CTC, toggle on both compares
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRA, 8'h52, 1'b0, 3'b000,
			tc8_pkg::ADR_TCCRA));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRB, 8'h01, 1'b0, 3'b000,
			tc8_pkg::ADR_TCCRB));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b0, 3'b000, tc8_pkg::ADR_TCNT));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b0, 3'b000, 8'h00));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b0, 3'b000, tc8_pkg::ADR_TIFR));
		// counter write lands on a compare value: match suppressed
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCNT, 8'h02, 1'b0, 3'b000,
			tc8_pkg::ADR_TCNT));
		// reserved mode 6 plus force compare on both channels
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRB, 8'hC9, 1'b0, 3'b000,
			tc8_pkg::ADR_TCCRB));
		// fast PWM with TOP from OCRA, toggle on A, set on B
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRA, 8'h73, 1'b0, 3'b000,
			tc8_pkg::ADR_TIFR));
		// force compare ignored in PWM, clock from T0 falling edge
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRB, 8'hCE, 1'b1, 3'b000,
			tc8_pkg::ADR_TCCRB));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b1, 3'b000, tc8_pkg::ADR_TCNT));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b0, 3'b000, tc8_pkg::ADR_TCNT));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b0, 3'b000, tc8_pkg::ADR_TCNT));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b0, 3'b000, tc8_pkg::ADR_TCNT));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRB, 8'h0F, 1'b1, 3'b000,
			tc8_pkg::ADR_TCNT));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b1, 3'b000, tc8_pkg::ADR_TCNT));
		send_cycle(make_cycle(1'b0, 8'h00, 8'h00, 1'b1, 3'b000, tc8_pkg::ADR_TCNT));
		// prescaler hold with both reset bits, then release
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_GTCCR, 8'h83, 1'b0, 3'b000,
			tc8_pkg::ADR_GTCCR));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_GTCCR, 8'h00, 1'b0, 3'b000,
			tc8_pkg::ADR_GTCCR));
		send_cycle(make_cycle(1'b1, 8'hFF, 8'hFF, 1'b0, 3'b000, 8'hFF));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TIFR, 8'h07, 1'b0, 3'b111,
			tc8_pkg::ADR_TIFR));
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRA, 8'h00, 1'b0, 3'b000,
			tc8_pkg::ADR_TCCRA));
		// reserved mode 4, divide by 256
		send_cycle(make_cycle(1'b1, tc8_pkg::ADR_TCCRB, 8'h0C, 1'b0, 3'b000,
			tc8_pkg::ADR_TCCRB));
		drain();
	endtask

	task automatic test_back_to_back;
		sender_idle_pct = 0;
		stall_pct = 0;
		run_random(420);
		drain();
	endtask

	task automatic test_sparse_input;
		sender_idle_pct = 88;
		stall_pct = 0;
		run_random(420);
		drain();
	endtask

	task automatic test_slow_output;
		sender_idle_pct = 0;
		stall_pct = 88;
		run_random(420);
		drain();
	endtask

	task automatic test_mixed_gaps;
		sender_idle_pct = 19;
		stall_pct = 19;
		run_random(420);
		drain();
	endtask

	task automatic test_output_backpressure;
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_tag++;
		run_random(150);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		{req_type, reg_addr, write_data, ext_clock_pin, ack_overflow, ack_compare_a,
			ack_compare_b, read_addr} = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_register_map_and_modes();
		test_back_to_back();
		test_sparse_input();
		test_slow_output();
		test_mixed_gaps();
		test_output_backpressure();

		repeat (10) @(posedge clk);
		$display("%0d timer cycles sent, %0d results checked", items_sent, views_checked);
		$display("%0d counter ticks, %0d overflows, %0d compare matches predicted",
			timer_ticks, overflow_events, match_events);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
